[sv/ccp_pkg.sv]
package ccp_pkg;

    // Width of every coordinate port
    localparam int IN_W     = 9;
    // Widest coordinate the datapath is built for
    localparam int IN_MAX_W = 10;
    // Width of the result ports
    localparam int OUT_BITS = 30;

    localparam logic signed [63:0] SAT_MAX = 64'sd536870911;
    localparam logic signed [63:0] SAT_MIN = -64'sd536870912;
    localparam logic [63:0]        RAD_MAX = 64'd1073741823;

endpackage

[sv/ccp_div_cell.sv]
module ccp_div_cell #(
    parameter int MW = 30,
    parameter int DW = 21,
    parameter int SW = 21
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [DW-1:0] i_div,
    input  logic [DW-1:0] i_rem_x,
    input  logic [MW-1:0] i_acc_x,
    input  logic [DW-1:0] i_rem_y,
    input  logic [MW-1:0] i_acc_y,
    input  logic [SW-1:0] i_side,
    output logic [DW-1:0] o_div,
    output logic [DW-1:0] o_rem_x,
    output logic [MW-1:0] o_acc_x,
    output logic [DW-1:0] o_rem_y,
    output logic [MW-1:0] o_acc_y,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   w_tx, w_ty, w_dv;
    logic          w_gx, w_gy;
    logic [DW-1:0] n_rem_x, n_rem_y;
    logic [MW-1:0] n_acc_x, n_acc_y;
    logic [DW-1:0] r_div, r_rem_x, r_rem_y;
    logic [MW-1:0] r_acc_x, r_acc_y;
    logic [SW-1:0] r_side;

    // One restoring step: bring down the next numerator bit, subtract if it fits
    always_comb begin
        w_dv    = {1'b0, i_div};
        w_tx    = {i_rem_x, i_acc_x[MW-1]};
        w_ty    = {i_rem_y, i_acc_y[MW-1]};
        w_gx    = (w_tx >= w_dv);
        w_gy    = (w_ty >= w_dv);
        n_rem_x = w_gx ? DW'(w_tx - w_dv) : DW'(w_tx);
        n_rem_y = w_gy ? DW'(w_ty - w_dv) : DW'(w_ty);
        n_acc_x = {i_acc_x[MW-2:0], w_gx};
        n_acc_y = {i_acc_y[MW-2:0], w_gy};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_div   <= i_div;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            r_side  <= i_side;
        end
    end

    assign o_div   = r_div;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;
    assign o_side  = r_side;

endmodule

[sv/ccp_sqrt_cell.sv]
module ccp_sqrt_cell #(
    parameter int RW = 31,
    parameter int SW = 61
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic [2*RW-1:0] i_rad,
    input  logic [RW+1:0]   i_rem,
    input  logic [RW-1:0]   i_root,
    input  logic [SW-1:0]   i_side,
    output logic [2*RW-1:0] o_rad,
    output logic [RW+1:0]   o_rem,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic [RW+3:0]   w_t, w_trial;
    logic            w_ge;
    logic [RW+1:0]   n_rem;
    logic [RW-1:0]   n_root;
    logic [2*RW-1:0] n_rad;
    logic [2*RW-1:0] r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [SW-1:0]   r_side;

    // One root digit: pull in two radicand bits, try (root*4 + 1)
    always_comb begin
        w_t     = {i_rem, i_rad[2*RW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_t >= w_trial);
        n_rem   = w_ge ? (RW+2)'(w_t - w_trial) : (RW+2)'(w_t);
        n_root  = {i_root[RW-2:0], w_ge};
        n_rad   = {i_rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;

endmodule

[sv/circumcircle_of_three_points_top.sv]
// Throughput: one triple per cycle unless stalled; each divider cell yields one quotient bit and
//   each root cell one root bit, all cells working on different triples at once.
// Stalls collapse bubbles: a stage loads whenever it or a later stage has room.
// Reset: synchronous, active low; clears every stage valid, payload is not reset.
module circumcircle_of_three_points_top
    import ccp_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [IN_W-1:0]            i_ax,
    input  logic [IN_W-1:0]            i_ay,
    input  logic [IN_W-1:0]            i_bx,
    input  logic [IN_W-1:0]            i_by_coord,
    input  logic [IN_W-1:0]            i_cx,
    input  logic [IN_W-1:0]            i_cy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_valid_res,
    output logic signed [OUT_BITS-1:0] o_center_x,
    output logic signed [OUT_BITS-1:0] o_center_y,
    output logic [OUT_BITS-1:0]        o_radius
);

    localparam int N    = COORD_BITS;
    localparam int CW   = N + 1;          // coordinate as signed
    localparam int FW   = N + 2;          // coordinate difference
    localparam int SQSW = 2 * N + 2;      // squared norm of a point
    localparam int DSW  = 2 * N + 4;      // determinant, signed
    localparam int DW   = 2 * N + 3;      // determinant magnitude
    localparam int NSW  = 3 * N + 4;      // numerator, signed
    localparam int MW   = 3 * N + 3;      // numerator magnitude, quotient
    localparam int SQW0 = 2 * MW + 1;
    localparam int SQ_W = (SQW0 > 64) ? 64 : SQW0;
    localparam int RW   = (SQ_W + 1) / 2;
    localparam int SDW  = 3 + 2 * N;      // divider side data
    localparam int SSW  = 1 + 2 * OUT_BITS;
    localparam int P_DIV = 4;
    localparam int P_UX  = P_DIV + MW;
    localparam int P_DX  = P_UX + 1;
    localparam int P_SQ  = P_DX + 1;
    localparam int P_SUM = P_SQ + 1;
    localparam int P_RT  = P_SUM + 1;
    localparam int P_OUT = P_RT + RW;
    localparam int NS    = P_OUT + 1;

    // Stage valids and per-stage load enables
    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    assign w_rdy[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = ~r_v[k] | w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];

    // Stage 0: register the coordinates, masked to COORD_BITS
    logic [IN_MAX_W-1:0]  w_eax, w_eay, w_ebx, w_eby, w_ecx, w_ecy;
    logic signed [CW-1:0] r0_ax, r0_ay, r0_bx, r0_by, r0_cx, r0_cy;

    assign w_eax = IN_MAX_W'(i_ax);
    assign w_eay = IN_MAX_W'(i_ay);
    assign w_ebx = IN_MAX_W'(i_bx);
    assign w_eby = IN_MAX_W'(i_by_coord);
    assign w_ecx = IN_MAX_W'(i_cx);
    assign w_ecy = IN_MAX_W'(i_cy);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_ax <= {1'b0, w_eax[N-1:0]};
            r0_ay <= {1'b0, w_eay[N-1:0]};
            r0_bx <= {1'b0, w_ebx[N-1:0]};
            r0_by <= {1'b0, w_eby[N-1:0]};
            r0_cx <= {1'b0, w_ecx[N-1:0]};
            r0_cy <= {1'b0, w_ecy[N-1:0]};
        end
    end

    // Stage 1: point norms, differences and the determinant
    logic signed [FW-1:0]   n1_dbc, n1_dca, n1_dab, n1_dcb, n1_dac, n1_dba;
    logic signed [DSW-1:0]  n1_d;
    logic signed [SQSW-1:0] r1_sa, r1_sb, r1_sc;
    logic signed [FW-1:0]   r1_dbc, r1_dca, r1_dab, r1_dcb, r1_dac, r1_dba;
    logic signed [DSW-1:0]  r1_d;
    logic [N-1:0]           r1_ax, r1_ay;

    always_comb begin
        n1_dbc = FW'(r0_by) - FW'(r0_cy);
        n1_dca = FW'(r0_cy) - FW'(r0_ay);
        n1_dab = FW'(r0_ay) - FW'(r0_by);
        n1_dcb = FW'(r0_cx) - FW'(r0_bx);
        n1_dac = FW'(r0_ax) - FW'(r0_cx);
        n1_dba = FW'(r0_bx) - FW'(r0_ax);
        n1_d   = (DSW'(r0_ax) * DSW'(n1_dbc) + DSW'(r0_bx) * DSW'(n1_dca)
                + DSW'(r0_cx) * DSW'(n1_dab)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_sa  <= SQSW'(r0_ax) * SQSW'(r0_ax) + SQSW'(r0_ay) * SQSW'(r0_ay);
            r1_sb  <= SQSW'(r0_bx) * SQSW'(r0_bx) + SQSW'(r0_by) * SQSW'(r0_by);
            r1_sc  <= SQSW'(r0_cx) * SQSW'(r0_cx) + SQSW'(r0_cy) * SQSW'(r0_cy);
            r1_dbc <= n1_dbc;
            r1_dca <= n1_dca;
            r1_dab <= n1_dab;
            r1_dcb <= n1_dcb;
            r1_dac <= n1_dac;
            r1_dba <= n1_dba;
            r1_d   <= n1_d;
            r1_ax  <= r0_ax[N-1:0];
            r1_ay  <= r0_ay[N-1:0];
        end
    end

    // Stage 2: centre numerators
    logic signed [NSW-1:0] r2_nx, r2_ny;
    logic signed [DSW-1:0] r2_d;
    logic [N-1:0]          r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_nx <= NSW'(r1_sa) * NSW'(r1_dbc) + NSW'(r1_sb) * NSW'(r1_dca)
                   + NSW'(r1_sc) * NSW'(r1_dab);
            r2_ny <= NSW'(r1_sa) * NSW'(r1_dcb) + NSW'(r1_sb) * NSW'(r1_dac)
                   + NSW'(r1_sc) * NSW'(r1_dba);
            r2_d  <= r1_d;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
        end
    end

    // Stage 3: split into sign and magnitude for the divider
    logic signed [NSW-1:0] n3_anx, n3_any;
    logic signed [DSW-1:0] n3_ad;
    logic [MW-1:0]         r3_nxm, r3_nym;
    logic [DW-1:0]         r3_dm;
    logic [SDW-1:0]        r3_side;

    always_comb begin
        n3_anx = r2_nx[NSW-1] ? -r2_nx : r2_nx;
        n3_any = r2_ny[NSW-1] ? -r2_ny : r2_ny;
        n3_ad  = r2_d[DSW-1]  ? -r2_d  : r2_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_nxm  <= n3_anx[MW-1:0];
            r3_nym  <= n3_any[MW-1:0];
            r3_dm   <= n3_ad[DW-1:0];
            r3_side <= {(r2_d != '0), r2_nx[NSW-1] ^ r2_d[DSW-1],
                        r2_ny[NSW-1] ^ r2_d[DSW-1], r2_ax, r2_ay};
        end
    end

    // Divider chain: one quotient bit per cell, both coordinates side by side
    logic [DW-1:0]  w_div   [0:MW];
    logic [DW-1:0]  w_rem_x [0:MW];
    logic [DW-1:0]  w_rem_y [0:MW];
    logic [MW-1:0]  w_acc_x [0:MW];
    logic [MW-1:0]  w_acc_y [0:MW];
    logic [SDW-1:0] w_dside [0:MW];

    assign w_div[0]   = r3_dm;
    assign w_rem_x[0] = '0;
    assign w_rem_y[0] = '0;
    assign w_acc_x[0] = r3_nxm;
    assign w_acc_y[0] = r3_nym;
    assign w_dside[0] = r3_side;

    for (genvar k = 0; k < MW; k++) begin : g_div
        ccp_div_cell #(
            .MW(MW),
            .DW(DW),
            .SW(SDW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_load  (w_rdy[P_DIV+k]),
            .i_div   (w_div[k]),
            .i_rem_x (w_rem_x[k]),
            .i_acc_x (w_acc_x[k]),
            .i_rem_y (w_rem_y[k]),
            .i_acc_y (w_acc_y[k]),
            .i_side  (w_dside[k]),
            .o_div   (w_div[k+1]),
            .o_rem_x (w_rem_x[k+1]),
            .o_acc_x (w_acc_x[k+1]),
            .o_rem_y (w_rem_y[k+1]),
            .o_acc_y (w_acc_y[k+1]),
            .o_side  (w_dside[k+1])
        );
    end

    // Restore the quotient sign: truncation toward zero falls out of magnitudes
    logic [SDW-1:0]        w_qs;
    logic signed [MW:0]    w_qx, w_qy;
    logic signed [MW:0]    r4_ux, r4_uy;
    logic [N-1:0]          r4_ax, r4_ay;
    logic                  r4_vres;

    assign w_qs = w_dside[MW];
    assign w_qx = signed'({1'b0, w_acc_x[MW]});
    assign w_qy = signed'({1'b0, w_acc_y[MW]});

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_UX]) begin
            r4_vres <= w_qs[SDW-1];
            r4_ux   <= w_qs[SDW-2] ? -w_qx : w_qx;
            r4_uy   <= w_qs[SDW-3] ? -w_qy : w_qy;
            r4_ax   <= w_qs[2*N-1:N];
            r4_ay   <= w_qs[N-1:0];
        end
    end

    // Distance components and the saturated centre
    logic signed [MW+1:0]     n5_ex, n5_ey, n5_aex, n5_aey;
    logic signed [63:0]       n5_ux, n5_uy;
    logic signed [OUT_BITS-1:0] n5_cx, n5_cy;
    logic [MW-1:0]            r5_dx, r5_dy;
    logic [SSW-1:0]           r5_side;

    always_comb begin
        n5_ex  = (MW+2)'(r4_ux) - signed'((MW+2)'(r4_ax));
        n5_ey  = (MW+2)'(r4_uy) - signed'((MW+2)'(r4_ay));
        n5_aex = n5_ex[MW+1] ? -n5_ex : n5_ex;
        n5_aey = n5_ey[MW+1] ? -n5_ey : n5_ey;
        n5_ux  = 64'(r4_ux);
        n5_uy  = 64'(r4_uy);
        if (n5_ux > SAT_MAX) begin
            n5_cx = OUT_BITS'(SAT_MAX);
        end else if (n5_ux < SAT_MIN) begin
            n5_cx = OUT_BITS'(SAT_MIN);
        end else begin
            n5_cx = OUT_BITS'(n5_ux);
        end
        if (n5_uy > SAT_MAX) begin
            n5_cy = OUT_BITS'(SAT_MAX);
        end else if (n5_uy < SAT_MIN) begin
            n5_cy = OUT_BITS'(SAT_MIN);
        end else begin
            n5_cy = OUT_BITS'(n5_uy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_DX]) begin
            r5_dx   <= n5_aex[MW-1:0];
            r5_dy   <= n5_aey[MW-1:0];
            r5_side <= {r4_vres, n5_cx, n5_cy};
        end
    end

    // Squares, then their sum kept modulo 2^SQ_W (SQ_W is at most 64)
    logic [2*MW-1:0] r6_sqx, r6_sqy;
    logic [SSW-1:0]  r6_side;
    logic [2*MW:0]   w_sum;
    logic [2*RW-1:0] r7_rad;
    logic [SSW-1:0]  r7_side;

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_SQ]) begin
            r6_sqx  <= (2*MW)'(r5_dx) * (2*MW)'(r5_dx);
            r6_sqy  <= (2*MW)'(r5_dy) * (2*MW)'(r5_dy);
            r6_side <= r5_side;
        end
    end

    assign w_sum = (2*MW+1)'(r6_sqx) + (2*MW+1)'(r6_sqy);

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_SUM]) begin
            r7_rad  <= (2*RW)'(w_sum[SQ_W-1:0]);
            r7_side <= r6_side;
        end
    end

    // Root chain: one root bit per cell
    logic [2*RW-1:0] w_rad  [0:RW];
    logic [RW+1:0]   w_rrem [0:RW];
    logic [RW-1:0]   w_root [0:RW];
    logic [SSW-1:0]  w_sside[0:RW];

    assign w_rad[0]   = r7_rad;
    assign w_rrem[0]  = '0;
    assign w_root[0]  = '0;
    assign w_sside[0] = r7_side;

    for (genvar k = 0; k < RW; k++) begin : g_rt
        ccp_sqrt_cell #(
            .RW(RW),
            .SW(SSW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_load (w_rdy[P_RT+k]),
            .i_rad  (w_rad[k]),
            .i_rem  (w_rrem[k]),
            .i_root (w_root[k]),
            .i_side (w_sside[k]),
            .o_rad  (w_rad[k+1]),
            .o_rem  (w_rrem[k+1]),
            .o_root (w_root[k+1]),
            .o_side (w_sside[k+1])
        );
    end

    // Output register: saturate the radius, zero everything for collinear points
    logic [SSW-1:0]             w_fs;
    logic [63:0]                w_r64;
    logic [OUT_BITS-1:0]        w_rad_c;
    logic                       r_vres;
    logic signed [OUT_BITS-1:0] r_cx, r_cy;
    logic [OUT_BITS-1:0]        r_rad;

    assign w_fs    = w_sside[RW];
    assign w_r64   = 64'(w_root[RW]);
    assign w_rad_c = (w_r64 > RAD_MAX) ? OUT_BITS'(RAD_MAX) : w_r64[OUT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[P_OUT]) begin
            r_vres <= w_fs[SSW-1];
            r_cx   <= w_fs[SSW-1] ? w_fs[2*OUT_BITS-1:OUT_BITS] : '0;
            r_cy   <= w_fs[SSW-1] ? w_fs[OUT_BITS-1:0] : '0;
            r_rad  <= w_fs[SSW-1] ? w_rad_c : '0;
        end
    end

    assign o_valid_res = r_vres;
    assign o_center_x  = r_cx;
    assign o_center_y  = r_cy;
    assign o_radius    = r_rad;

    // Collinear results carry all-zero geometry
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_center_x == '0 && o_center_y == '0 && o_radius == '0))
        else $error("collinear result with nonzero fields");

    // An empty pipeline always takes a transfer
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> o_ready)
        else $error("empty pipeline refuses input");

    // A waiting result is never dropped, nor its radius or centre x changed, by the bubble logic
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_radius) && $stable(o_center_x)))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("stage valid survived reset");

endmodule

[bench/tb_circumcircle_of_three_points_top.sv]
module tb_circumcircle_of_three_points_top
    import ccp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IN_W-1:0] ax, ay, bx, by, cx, cy;
    } t_triple;

    typedef struct packed {
        logic                       ok;
        logic signed [OUT_BITS-1:0] ux;
        logic signed [OUT_BITS-1:0] uy;
        logic [OUT_BITS-1:0]        r;
    } t_circle;

    localparam int COORD_BITS = 9;
    localparam int LIMIT = 400000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [IN_W-1:0]            i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy;
    logic                       o_valid;
    logic                       i_ready;
    logic                       o_valid_res;
    logic signed [OUT_BITS-1:0] o_center_x;
    logic signed [OUT_BITS-1:0] o_center_y;
    logic [OUT_BITS-1:0]        o_radius;

    int mismatches = 0;
    int cycle = 0;
    bit sink_busy_free = 0;

    circumcircle_of_three_points_top #(.COORD_BITS(COORD_BITS)) i_dut (.*);

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d, want %0d", what, $signed(got), $signed(want));
        mismatches++;
    endtask

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Compute the circle through a triple, all intermediates in 64 bits.
    function automatic t_circle circle_of(t_triple t);
        t_circle c;
        longint ax, ay, bx, by, cx, cy, d, sa, sb, sc, nx, ny, qx, qy, dx, dy;
        logic [63:0] rr;
        longint msk;
        msk = (64'd1 << COORD_BITS) - 1;
        ax = t.ax & msk; ay = t.ay & msk; bx = t.bx & msk;
        by = t.by & msk; cx = t.cx & msk; cy = t.cy & msk;
        c = '0;
        d = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
        if (d == 0) return c;
        sa = ax * ax + ay * ay;
        sb = bx * bx + by * by;
        sc = cx * cx + cy * cy;
        nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
        ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
        qx = nx / d;
        qy = ny / d;
        dx = (qx >= ax) ? qx - ax : ax - qx;
        dy = (qy >= ay) ? qy - ay : ay - qy;
        rr = floor_sqrt(64'(dx * dx) + 64'(dy * dy));
        if (rr > RAD_MAX) rr = RAD_MAX;
        c.ok = 1'b1;
        c.ux = (qx > SAT_MAX) ? SAT_MAX[OUT_BITS-1:0] :
               (qx < SAT_MIN) ? SAT_MIN[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
        c.uy = (qy > SAT_MAX) ? SAT_MAX[OUT_BITS-1:0] :
               (qy < SAT_MIN) ? SAT_MIN[OUT_BITS-1:0] : qy[OUT_BITS-1:0];
        c.r = rr[OUT_BITS-1:0];
        return c;
    endfunction

    class t_circle_board;
        t_circle pending[$];

        function void note_triple(t_triple t);
            pending = {pending, circle_of(t)};
        endfunction

        task check_circle(t_circle got);
            t_circle want;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(got.ok), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok) report("valid_res", 64'(got.ok), 64'(want.ok));
            if (got.ux !== want.ux) report("center_x", 64'(got.ux), 64'(want.ux));
            if (got.uy !== want.uy) report("center_y", 64'(got.uy), 64'(want.uy));
            if (got.r !== want.r) report("radius", 64'(got.r), 64'(want.r));
        endtask
    endclass

    t_circle_board board = new();

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on cycles.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample both transfers at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            board.note_triple({i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy});
        if (i_rst_n && o_valid && i_ready)
            board.check_circle({o_valid_res, o_center_x, o_center_y, o_radius});
    end

    // Random backpressure on the result side, with an idle-free window.
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            i_ready <= sink_busy_free ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    // Present one triple and hold it until the transfer happens.
    task automatic send_triple(t_triple t, bit no_gaps);
        while (!no_gaps && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy} <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_triple random_triple();
        t_triple t;
        logic [63:0] rnd;
        int k;
        k = $urandom_range(9);
        rnd = {$urandom, $urandom};
        t = rnd[$bits(t_triple)-1:0];
        if (k == 0) begin
            // collinear: b and c on a line through a
            t.bx = t.ax; t.cx = t.ax;
        end else if (k == 1) begin
            t.bx = t.ax; t.by = t.ay;
        end else if (k == 2) begin
            // nearly collinear, small area
            t.bx = t.ax + 9'($urandom_range(255));
            t.by = t.ay + 9'($urandom_range(2));
            t.cx = t.bx + 9'($urandom_range(255));
            t.cy = t.by + 9'($urandom_range(2));
        end
        return t;
    endfunction

    initial begin
        t_triple directed [12];
        int n;
        i_rst_n = 0;
        i_valid = 0;
        {i_ax, i_ay, i_bx, i_by_coord, i_cx, i_cy} = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        directed = '{
            {9'd0, 9'd0, 9'd511, 9'd0, 9'd0, 9'd511},
            {9'd511, 9'd511, 9'd0, 9'd511, 9'd511, 9'd0},
            {9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
            {9'd511, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511},
            {9'd0, 9'd0, 9'd1, 9'd1, 9'd2, 9'd2},
            {9'd0, 9'd0, 9'd511, 9'd1, 9'd510, 9'd0},
            {9'd0, 9'd0, 9'd1, 9'd0, 9'd511, 9'd1},
            {9'd0, 9'd511, 9'd511, 9'd0, 9'd1, 9'd510},
            {9'd10, 9'd10, 9'd20, 9'd10, 9'd10, 9'd20},
            {9'd5, 9'd3, 9'd5, 9'd3, 9'd100, 9'd7},
            {9'd0, 9'd0, 9'd1, 9'd0, 9'd0, 9'd1},
            {9'd511, 9'd0, 9'd0, 9'd0, 9'd255, 9'd1}
        };
        foreach (directed[i]) send_triple(directed[i], 1'b0);

        // Drain completely before the random stream.
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);

        for (n = 0; n < 950; n++) begin
            sink_busy_free = (n >= 300 && n < 450);
            send_triple(random_triple(), sink_busy_free);
        end
        sink_busy_free = 0;
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
